>>> hw/rtl/bdeq_pkg.sv
// Package for the bounded double-ended queue: depth, widths, operation,
// status and cell control codes shared by the cells, top level and checker.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bdeq_pkg;

	localparam int DEPTH = 16;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int WORD_W = 32;

	localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
	localparam logic [2:0] MODE_PUSH_REAR  = 3'd1;
	localparam logic [2:0] MODE_POP_FRONT  = 3'd2;
	localparam logic [2:0] MODE_POP_REAR   = 3'd3;
	localparam logic [2:0] MODE_LIST       = 3'd4;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_SHL,
		CELL_SHR,
		CELL_LOAD
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
	} cell_ctrl_t;

endpackage

`default_nettype wire

>>> hw/rtl/bdeq_cell.sv
// One storage cell of the queue chain: holds a word, takes a neighbor's
// word on a shift or the shared load word. Depends on bdeq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bdeq_cell
	import bdeq_pkg::*;
(
	input  wire logic              clk,
	input  wire cell_ctrl_t        ctrl,
	input  wire logic [WORD_W-1:0] from_left,
	input  wire logic [WORD_W-1:0] from_right,
	input  wire logic [WORD_W-1:0] load_data,
	output logic      [WORD_W-1:0] word_q
);

	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			CELL_HOLD: word_q <= word_q;
			CELL_SHL:  word_q <= from_right;
			CELL_SHR:  word_q <= from_left;
			CELL_LOAD: word_q <= load_data;
			default:   word_q <= word_q;
		endcase
	end

endmodule

`default_nettype wire

>>> hw/rtl/bounded_double_ended_queue_unit.sv
// Top level of the bounded double-ended queue: a row of bdeq_cell storage
// cells, the operation sequencer and the output register.
// Depends on bdeq_pkg and bdeq_cell.
//
// Input words: s_tuser carries the operation (push front, push rear, pop
// front, pop rear, list all), s_tdata the word to push. Output words:
// m_tdata is the popped or listed word (zero when none), m_tuser holds the
// status and the word-valid flag, m_tlast marks the final word of an item.
// Word 0 always sits at the front cell; pushes and pops at the front shift
// the whole row; a push at the rear loads the cell at the occupancy, a pop at
// the rear reads the cell below it. Push and pop answer in the cycle after
// acceptance; a new item is taken every cycle while no list runs and the
// output register is free or drained. A list holds the input until its last
// word is sent: the sequencer enters its list state, then while the output
// register is free the row rotates one cell per cycle and sends the front cell.
// Unused operation codes are accepted and give no word.
// Reset empties the queue and the output register; cell contents are not
// cleared. When m_tready is low and a word waits, it holds and s_tready falls.
`timescale 1ns / 1ps
`default_nettype none

module bounded_double_ended_queue_unit
	import bdeq_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [31:0]       s_tdata,   // [31:0] value
	input  wire logic [7:0]        s_tuser,   // [2:0] mode, [7:3] zero
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic      [31:0]       m_tdata,   // [31:0] word
	output logic      [7:0]        m_tuser,   // [1:0] status, [2] word_valid, [7:3] zero
	output logic                   m_tlast
);

	localparam logic STATE_IDLE = 1'b0;
	localparam logic STATE_LIST = 1'b1;

	logic              state_q, state_d;
	logic [CNT_W-1:0]  occ_q, occ_d;
	logic [IDX_W-1:0]  cnt_q, cnt_d;
	logic [WORD_W-1:0] cells [DEPTH];
	cell_ctrl_t        ctrl [DEPTH];
	logic [WORD_W-1:0] load_data;

	logic              m_valid_q;
	logic [1:0]        status_q;
	logic [WORD_W-1:0] word_q;
	logic              wvalid_q;
	logic              last_q;

	logic              out_load;
	logic [1:0]        out_status;
	logic [WORD_W-1:0] out_word;
	logic              out_wvalid;
	logic              out_last;

	logic              slot_free;
	logic              accept;
	logic [2:0]        mode;
	logic              full;
	logic              empty;
	logic [CNT_W-1:0]  tail;
	logic [IDX_W-1:0]  tail_idx;

	assign mode      = s_tuser[2:0];
	assign slot_free = !m_valid_q || m_tready;
	assign s_tready  = (state_q == STATE_IDLE) && slot_free;
	assign accept    = s_tvalid && s_tready;
	assign full      = (occ_q == CNT_W'(DEPTH));
	assign empty     = (occ_q == '0);
	assign tail      = occ_q - CNT_W'(1);
	assign tail_idx  = tail[IDX_W-1:0];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [WORD_W-1:0] left_w, right_w;
		if (i == 0) begin : g_first
			assign left_w = s_tdata;
		end else begin : g_mid
			assign left_w = cells[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_rest
			assign right_w = cells[i+1];
		end
		bdeq_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl[i]),
			.from_left  (left_w),
			.from_right (right_w),
			.load_data  (load_data),
			.word_q     (cells[i])
		);
	end

	always_comb begin
		state_d    = state_q;
		occ_d      = occ_q;
		cnt_d      = cnt_q;
		load_data  = s_tdata;
		out_load   = 1'b0;
		out_status = STATUS_OK;
		out_word   = '0;
		out_wvalid = 1'b0;
		out_last   = 1'b1;
		for (int i = 0; i < DEPTH; i++) begin
			ctrl[i].op = CELL_HOLD;
		end
		if (state_q == STATE_IDLE) begin
			if (accept) begin
				unique case (mode)
					MODE_PUSH_FRONT: begin
						out_load = 1'b1;
						if (full) begin
							out_status = STATUS_FULL;
						end else begin
							for (int i = 0; i < DEPTH; i++) begin
								ctrl[i].op = CELL_SHR;
							end
							occ_d = occ_q + CNT_W'(1);
						end
					end
					MODE_PUSH_REAR: begin
						out_load = 1'b1;
						if (full) begin
							out_status = STATUS_FULL;
						end else begin
							ctrl[occ_q[IDX_W-1:0]].op = CELL_LOAD;
							occ_d = occ_q + CNT_W'(1);
						end
					end
					MODE_POP_FRONT: begin
						out_load = 1'b1;
						if (empty) begin
							out_status = STATUS_EMPTY;
						end else begin
							out_word   = cells[0];
							out_wvalid = 1'b1;
							for (int i = 0; i < DEPTH; i++) begin
								ctrl[i].op = CELL_SHL;
							end
							occ_d = tail;
						end
					end
					MODE_POP_REAR: begin
						out_load = 1'b1;
						if (empty) begin
							out_status = STATUS_EMPTY;
						end else begin
							out_word   = cells[tail_idx];
							out_wvalid = 1'b1;
							occ_d      = tail;
						end
					end
					MODE_LIST: begin
						if (empty) begin
							out_load   = 1'b1;
							out_status = STATUS_EMPTY;
						end else begin
							state_d = STATE_LIST;
							cnt_d   = '0;
						end
					end
					default: begin
					end
				endcase
			end
		end else if (slot_free) begin
			out_load   = 1'b1;
			out_word   = cells[0];
			out_wvalid = 1'b1;
			out_last   = (cnt_q == tail_idx);
			load_data  = cells[0];
			for (int i = 0; i < DEPTH; i++) begin
				if (IDX_W'(i) < tail_idx) begin
					ctrl[i].op = CELL_SHL;
				end else if (IDX_W'(i) == tail_idx) begin
					ctrl[i].op = CELL_LOAD;
				end
			end
			cnt_d = cnt_q + IDX_W'(1);
			if (out_last) begin
				state_d = STATE_IDLE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= STATE_IDLE;
			occ_q     <= '0;
			cnt_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			occ_q   <= occ_d;
			cnt_q   <= cnt_d;
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			status_q <= out_status;
			word_q   <= out_word;
			wvalid_q <= out_wvalid;
			last_q   <= out_last;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = word_q;
	assign m_tuser  = {5'b0, wvalid_q, status_q};
	assign m_tlast  = last_q;

endmodule

`default_nettype wire

>>> hw/rtl/bdeq_checker.sv
// Port-level checker for bounded_double_ended_queue_unit and its bind.
// Depends on bdeq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bdeq_checker
	import bdeq_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic [7:0]  s_tuser,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata,
	input wire logic [7:0]  m_tuser,
	input wire logic        m_tlast
);

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output word dropped while stalled");

	a_valid_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2] |-> m_tuser[1:0] == STATUS_OK)
		else $error("word marked valid with error status");

	a_error_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1:0] != STATUS_OK |-> m_tlast)
		else $error("error status without last");

	a_zero_word: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[2] |-> m_tdata == '0)
		else $error("nonzero word without word_valid");

	a_push_answers: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready &&
		(s_tuser[2:0] == MODE_PUSH_FRONT || s_tuser[2:0] == MODE_PUSH_REAR)
		|=> m_tvalid && m_tlast)
		else $error("push gave no status word");

endmodule

bind bounded_double_ended_queue_unit bdeq_checker u_bdeq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

`default_nettype wire

>>> verif/bdeq_checker.sv
// Checker for the bounded double-ended queue: watches both stream channels,
// keeps its own copy of the queue and compares every output word in order.
// Depends on bdeq_pkg.
`timescale 1ns / 1ps

module bdeq_scoreboard
	import bdeq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] value
	input  logic [7:0]  s_tuser,   // [2:0] mode, [7:3] zero
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,   // [31:0] word
	input  logic [7:0]  m_tuser,   // [1:0] status, [2] word_valid, [7:3] zero
	input  logic        m_tlast,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic [1:0]        status;
		logic [WORD_W-1:0] word;
		logic              word_valid;
		logic              last;
	} deq_result_t;

	logic [WORD_W-1:0] deq_store [DEPTH];
	int deq_head = 0;
	int deq_count = 0;
	deq_result_t expected_words [$];

	function automatic void expect_result(input logic [1:0] status,
			input logic [WORD_W-1:0] word, input logic word_valid, input logic last);
		deq_result_t r;
		r.status = status;
		r.word = word;
		r.word_valid = word_valid;
		r.last = last;
		expected_words.push_back(r);
	endfunction

	task automatic predict_item(input logic [2:0] mode, input logic [WORD_W-1:0] value);
		int slot;
		case (mode)
		MODE_PUSH_FRONT, MODE_PUSH_REAR: begin
			if (deq_count == DEPTH) begin
				expect_result(STATUS_FULL, '0, 1'b0, 1'b1);
			end else begin
				if (mode == MODE_PUSH_FRONT) begin
					deq_head = (deq_head + DEPTH - 1) % DEPTH;
					slot = deq_head;
				end else begin
					slot = (deq_head + deq_count) % DEPTH;
				end
				deq_store[slot] = value;
				deq_count++;
				expect_result(STATUS_OK, '0, 1'b0, 1'b1);
			end
		end
		MODE_POP_FRONT: begin
			if (deq_count == 0) begin
				expect_result(STATUS_EMPTY, '0, 1'b0, 1'b1);
			end else begin
				expect_result(STATUS_OK, deq_store[deq_head], 1'b1, 1'b1);
				deq_head = (deq_head + 1) % DEPTH;
				deq_count--;
			end
		end
		MODE_POP_REAR: begin
			if (deq_count == 0) begin
				expect_result(STATUS_EMPTY, '0, 1'b0, 1'b1);
			end else begin
				slot = (deq_head + deq_count - 1) % DEPTH;
				expect_result(STATUS_OK, deq_store[slot], 1'b1, 1'b1);
				deq_count--;
			end
		end
		MODE_LIST: begin
			if (deq_count == 0) begin
				expect_result(STATUS_EMPTY, '0, 1'b0, 1'b1);
			end else begin
				for (int i = 0; i < deq_count; i++) begin
					expect_result(STATUS_OK, deq_store[(deq_head + i) % DEPTH], 1'b1,
						i == deq_count - 1);
				end
			end
		end
		default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		deq_result_t want;
		if (!arst_n) begin
			deq_head = 0;
			deq_count = 0;
			fail_count = 0;
			expected_words.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_words.size() == 0) begin
					$error("unexpected word: status %0d word %0d word_valid %0d last %0d",
						m_tuser[1:0], $signed(m_tdata), m_tuser[2], m_tlast);
					fail_count++;
				end else begin
					want = expected_words.pop_front();
					if (m_tuser[1:0] !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, m_tuser[1:0]);
						fail_count++;
					end
					if (m_tdata !== want.word) begin
						$error("word: expected %0d, got %0d", $signed(want.word),
							$signed(m_tdata));
						fail_count++;
					end
					if (m_tuser[2] !== want.word_valid) begin
						$error("word_valid: expected %0d, got %0d", want.word_valid,
							m_tuser[2]);
						fail_count++;
					end
					if (m_tlast !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, m_tlast);
						fail_count++;
					end
				end
			end
			if (s_tvalid && s_tready)
				predict_item(s_tuser[2:0], s_tdata);
		end
		pending = expected_words.size();
	end

endmodule

>>> verif/tb.sv
// Testbench top for bounded_double_ended_queue_unit: directed and random
// operation streams with bursty input and a stalling output side.
// Depends on bdeq_pkg, bounded_double_ended_queue_unit and bdeq_scoreboard.
`timescale 1ns / 1ps

module tb;
	import bdeq_pkg::*;

	localparam int TOTAL_ITEMS = 470;
	localparam int PHASE_ITEMS = 40;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;   // [31:0] value
	logic [7:0]  s_tuser = '0;   // [2:0] mode, [7:3] zero
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;        // [31:0] word
	logic [7:0]  m_tuser;        // [1:0] status, [2] word_valid, [7:3] zero
	logic        m_tlast;
	int          fail_count;
	int          pending;

	int stall_left = 0;
	int cycle_count = 0;

	bounded_double_ended_queue_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	bdeq_scoreboard u_scoreboard (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast), .fail_count(fail_count), .pending(pending)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// receiver: free-running, light stalls, heavy stalls, in turn
	always @(posedge clk) begin
		cycle_count++;
		if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else begin
			m_tready <= 1'b1;
			case ((cycle_count / 256) % 3)
			1: if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 3);
			2: if ($urandom_range(0, 1) == 0) stall_left = $urandom_range(1, 6);
			default: ;
			endcase
		end
	end

	task automatic send_word(input logic [2:0] mode, input logic [31:0] value);
		s_tvalid <= 1'b1;
		s_tdata <= value;
		s_tuser <= {5'b0, mode};
		do @(posedge clk); while (!s_tready);
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 15))
		0: return 32'h8000_0000;
		1: return 32'h7fff_ffff;
		2: return 32'h0000_0000;
		3: return 32'hffff_ffff;
		default: return $urandom;
		endcase
	endfunction

	// fill leans to pushes, drain to pops, mixed is even
	function automatic logic [2:0] pick_mode(input int lean);
		int r;
		r = $urandom_range(0, 99);
		if (r < 3)
			return 3'($urandom_range(5, 7));
		if (r < 10)
			return MODE_LIST;
		if ((lean == 0 && r < 25) || (lean == 1 && r >= 25) || (lean == 2 && r < 55))
			return $urandom_range(0, 1) ? MODE_POP_FRONT : MODE_POP_REAR;
		return $urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_REAR;
	endfunction

	initial begin
		int counted;
		int burst_left;
		int gap;
		int drain_wait;
		bit no_gaps;
		logic [2:0] mode;
		logic [31:0] fill_values [8];

		fill_values = '{32'h0000_0000, 32'hffff_ffff, 32'h5555_5555, 32'haaaa_aaaa,
			32'h8000_0001, 32'h7fff_fffe, 32'h0000_0001, 32'h1234_5678};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		counted = 0;
		send_word(MODE_LIST, 32'h0);
		send_word(MODE_POP_FRONT, 32'h0);
		send_word(MODE_POP_REAR, 32'h0);
		send_word(3'd5, 32'hffff_ffff);
		send_word(3'd6, 32'h0);
		send_word(3'd7, 32'h8000_0000);
		send_word(MODE_PUSH_FRONT, 32'h7fff_ffff);
		send_word(MODE_POP_REAR, 32'h0);
		send_word(MODE_PUSH_REAR, 32'h8000_0000);
		send_word(MODE_POP_FRONT, 32'h0);
		counted = 7;
		for (int i = 0; i < DEPTH; i++) begin
			send_word(i % 2 ? MODE_PUSH_REAR : MODE_PUSH_FRONT, fill_values[i % 8] ^ i);
			counted++;
		end
		send_word(MODE_PUSH_REAR, 32'hdead_beef);
		send_word(MODE_PUSH_FRONT, 32'h0bad_f00d);
		send_word(MODE_LIST, 32'h0);
		counted += 3;

		burst_left = $urandom_range(1, 16);
		no_gaps = 1'b0;
		while (counted < TOTAL_ITEMS) begin
			mode = pick_mode((counted / PHASE_ITEMS) % 3);
			send_word(mode, pick_value());
			if (mode <= MODE_LIST)
				counted++;
			if (counted % 100 == 0)
				no_gaps = $urandom_range(0, 2) == 0;
			burst_left--;
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 16);
				gap = no_gaps ? 0 : $urandom_range(0, 6);
				if (gap > 0) begin
					s_tvalid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
		s_tvalid <= 1'b0;

		drain_wait = 0;
		do begin
			@(negedge clk);
			drain_wait++;
		end while (pending != 0 && drain_wait < 100000);

		if (pending != 0) begin
			$display("SCOREBOARD MISMATCH");
		end else begin
			repeat (20) @(posedge clk);
			if (fail_count == 0)
				$display("SCOREBOARD CLEAN");
			else
				$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
